// ===== hdl/mbet_pkg.sv =====
package mbet_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W = COORD_W - 4;
  localparam int ITER_W = 19;
  localparam int PROD_W = 2 * COORD_W;
  // update sums: products shifted down by FRAC_W (FRAC_W-1 for x*y) plus c, with headroom
  localparam int UPD_W = COORD_W + 8;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [ITER_W-1:0] RESET_MAX_ITER = ITER_W'(500000);

  // register indexes
  localparam logic REG_MAX_ITER = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [ITER_W-1:0] iteration_count;
    logic              escaped;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic below_max;
    logic escape;
  } ctrl_status_t;

endpackage

// ===== hdl/mbet_datapath.sv =====
module mbet_datapath (
  input  logic                             clk,
  input  mbet_pkg::in_item_t               in_data,
  input  logic [mbet_pkg::ITER_W-1:0]      max_iter,
  input  mbet_pkg::ctrl_cmd_t              cmd,
  output mbet_pkg::ctrl_status_t           status,
  output mbet_pkg::out_item_t              out_data
);

  localparam int CW = mbet_pkg::COORD_W;
  localparam int NW = mbet_pkg::UPD_W;
  localparam int PW = mbet_pkg::PROD_W;

  localparam logic signed [NW-1:0] SAT_HI = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NW-1:0] SAT_LO = {{(NW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  // 4.0 with 2*FRAC_W fraction bits
  localparam logic [PW:0] FOUR = (PW+1)'(1) << (2 * mbet_pkg::FRAC_W + 2);

  logic signed [CW-1:0] cr_r, ci_r, x_r, y_r;
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic [mbet_pkg::ITER_W-1:0] it_r;
  logic signed [PW-1:0] xx_r, yy_r, xy_r;
  logic signed [PW-1:0] xx_nxt, yy_nxt, xy_nxt;
  logic [PW:0] mag_sq;
  logic signed [NW-1:0] xn, yn;
  mbet_pkg::out_item_t out_r;

  function automatic logic signed [CW-1:0] sat(input logic signed [NW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  assign xx_nxt = x_r * x_r;
  assign yy_nxt = y_r * y_r;
  assign xy_nxt = x_r * y_r;

  // squares are never negative, so the exact sum fits one extra bit
  assign mag_sq = {1'b0, xx_r} + {1'b0, yy_r};

  assign xn = NW'(xx_r >>> mbet_pkg::FRAC_W) - NW'(yy_r >>> mbet_pkg::FRAC_W) + NW'(cr_r);
  assign yn = NW'(xy_r >>> (mbet_pkg::FRAC_W - 1)) + NW'(ci_r);
  assign x_nxt = sat(xn);
  assign y_nxt = sat(yn);

  assign status.below_max = (it_r < max_iter);
  assign status.escape = (mag_sq >= FOUR);

  always_ff @(posedge clk) begin
    xx_r <= xx_nxt;
    yy_r <= yy_nxt;
    xy_r <= xy_nxt;
    if (cmd.start) begin
      cr_r <= in_data.c_real;
      ci_r <= in_data.c_imag;
      x_r  <= '0;
      y_r  <= '0;
      it_r <= '0;
    end else if (cmd.step) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      it_r <= it_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_r.iteration_count <= it_r;
      out_r.escaped         <= status.below_max;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/mbet_ctrl.sv =====
module mbet_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  mbet_pkg::ctrl_status_t status,
  output mbet_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      // products of the current z are registered at the end of this cycle
      S_MUL: begin
        if (status.below_max) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        if (status.escape) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_MUL))
    else $error("accepted request did not start iterating");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_step_loops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !status.escape) |=> (state_r == S_MUL))
    else $error("iteration did not return to multiply");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing");
`endif

endmodule

// ===== hdl/mandelbrot_escape_time_top.sv =====
// mandelbrot escape-time iterator
// input channel (in_valid / in_stall / in_data): one point c as signed
// Q4.28 real and imaginary parts. a request is taken when in_valid is high
// and in_stall low; in_stall stays high while a point is being iterated.
// result channel (out_valid / out_stall / out_data): iteration count and
// escaped flag, held in an output register until taken. a new request can
// be taken while a result still waits there.
// config port (apb style, cfg_ prefix): register 0 at byte address 0 holds
// the iteration limit (19 bits), reset value 500000.
// timing: each iteration is a registered multiply cycle (three 32x32
// products) followed by a test/update cycle. a point finishes when it
// escapes or when its iteration count reaches the limit.
// reset (rst_n, synchronous) drops any point in flight and empties the
// output register. when the receiver stalls, the result stays put and a
// finished point waits before its result is loaded.
module mandelbrot_escape_time_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mbet_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mbet_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mbet_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [mbet_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [mbet_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  logic [mbet_pkg::ITER_W-1:0] max_iter_r;
  logic cfg_hit;
  mbet_pkg::ctrl_cmd_t cmd;
  mbet_pkg::ctrl_status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[2] == mbet_pkg::REG_MAX_ITER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= mbet_pkg::RESET_MAX_ITER;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      max_iter_r <= cfg_pwdata[mbet_pkg::ITER_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? mbet_pkg::APB_DW'(max_iter_r) : '0;

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mbet_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .max_iter (max_iter_r),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/mandelbrot_escape_time_top_test.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_time_top_test;
  import mbet_pkg::*;

  localparam int SPARE_REG = 1;
  localparam logic [APB_AW-1:0] LIMIT_ADDR = APB_AW'(4 * REG_MAX_ITER);
  localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * SPARE_REG);
  localparam int ONE_Q = 1 << FRAC_W;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [ITER_W-1:0] ITER_TOP = '1;

  class escape_board;
    out_item_t expected_q[$];
    logic [ITER_W-1:0] limit;
    int unsigned points, results, errors, deepest;

    function new();
      limit = RESET_MAX_ITER;
      points = 0;
      results = 0;
      errors = 0;
      deepest = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [APB_DW-1:0] value);
      if (idx == REG_MAX_ITER) limit = value[ITER_W-1:0];
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function logic signed [COORD_W-1:0] clamp_coord(logic signed [PROD_W+1:0] v);
      logic signed [PROD_W+1:0] top, bottom;
      top = '0;
      top[COORD_W-2:0] = '1;
      bottom = ~top;
      if (v > top) return top[COORD_W-1:0];
      if (v < bottom) return bottom[COORD_W-1:0];
      return v[COORD_W-1:0];
    endfunction

    // iterate z = z^2 + c from z = 0 with full-width products
    function out_item_t escape_time(in_item_t c);
      logic signed [PROD_W+1:0] xx, yy, xy, xn, yn, four;
      logic signed [COORD_W-1:0] x, y;
      int unsigned n;
      out_item_t r;
      four = '0;
      four[2*FRAC_W+2] = 1'b1;
      x = '0;
      y = '0;
      n = 0;
      while (n < limit) begin
        xx = x * x;
        yy = y * y;
        xy = x * y;
        if (xx + yy >= four) break;
        xn = (xx >>> FRAC_W) - (yy >>> FRAC_W) + $signed(c.c_real);
        yn = (xy >>> (FRAC_W - 1)) + $signed(c.c_imag);
        x = clamp_coord(xn);
        y = clamp_coord(yn);
        n++;
      end
      r.iteration_count = n[ITER_W-1:0];
      r.escaped = (n < limit);
      return r;
    endfunction

    function void note_point(in_item_t c);
      expected_q.push_back(escape_time(c));
      points++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with no point pending: count %0d escaped %0b",
                   got.iteration_count, got.escaped);
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (got.iteration_count > deepest) deepest = got.iteration_count;
      if (got.iteration_count !== want.iteration_count)
        report("iteration_count", want.iteration_count, got.iteration_count);
      if (got.escaped !== want.escaped) report("escaped", want.escaped, got.escaped);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  escape_board board = new();
  bit quiet;
  int unsigned hold_off;
  int unsigned limits_seen;

  mandelbrot_escape_time_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout: %0d points sent, %0d results seen", board.points, board.results);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function in_item_t point(logic signed [COORD_W-1:0] re, logic signed [COORD_W-1:0] im);
    in_item_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // |c| > 2, so the point leaves after one iteration
  function in_item_t far_point();
    int signed mag, other;
    mag = $urandom_range(9 * (ONE_Q / 4), 32'h7FFF_FFFF);
    if ($urandom_range(0, 1)) mag = -mag;
    other = $urandom();
    if ($urandom_range(0, 1)) return point(mag, other);
    return point(other, mag);
  endfunction

  function in_item_t random_point();
    int unsigned r;
    int signed re, im;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      re = -(5 * ONE_Q / 2) + int'($urandom_range(0, 7 * ONE_Q / 2));
      im = -(5 * ONE_Q / 4) + int'($urandom_range(0, 5 * ONE_Q / 2));
      return point(re, im);
    end
    if (r < 85) return point($urandom(), $urandom());
    return far_point();
  endfunction

  task send_point(input in_item_t p);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    board.note_point(p);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task random_points(input int unsigned count, input bit far_only);
    repeat (count) send_point(far_only ? far_point() : random_point());
    in_valid <= 1'b0;
  endtask

  task wait_idle();
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  task apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task apb_idle();
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task check_limit();
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, LIMIT_ADDR, '0, rd);
    if (rd !== APB_DW'(board.limit)) board.report("limit readback", board.limit, rd);
  endtask

  task set_limit(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, addr, value, rd);
    board.write_reg(addr >> 2, value);
    check_limit();
    apb_idle();
    limits_seen++;
  endtask

  // result side: check what is taken, then pick the next stall value
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 1'b0;
    hold_off = 0;
    limits_seen = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_limit();
    apb_idle();

    // reset limit is huge, so only points that leave at once
    send_point(point(C_MAX, C_MAX));
    send_point(point(C_MIN, C_MIN));
    send_point(point(C_MAX, C_MIN));
    send_point(point(C_MIN, C_MAX));
    send_point(point(C_MIN, '0));
    send_point(point('0, C_MAX));
    in_valid <= 1'b0;

    // zero limit: no iteration at all, never escaped
    set_limit(LIMIT_ADDR, '0);
    send_point(point('0, '0));
    send_point(point(C_MAX, '0));
    send_point(point(C_MIN, C_MIN));
    in_valid <= 1'b0;

    // bits above the limit width are dropped, leaving a limit of 3
    set_limit(LIMIT_ADDR, 32'hFFF8_0003);
    send_point(point('0, '0));
    send_point(point(-2 * ONE_Q, '0));
    send_point(point(2 * ONE_Q, '0));
    send_point(point(ONE_Q / 4, '0));
    send_point(point('0, ONE_Q));
    send_point(point(-ONE_Q, '0));
    in_valid <= 1'b0;

    // write to an unmapped register must leave the limit alone
    set_limit(SPARE_ADDR, 32'h0000_0007);
    send_point(point(ONE_Q / 2, ONE_Q / 2));
    send_point(point(-3 * ONE_Q / 4, ONE_Q / 8));
    in_valid <= 1'b0;

    set_limit(LIMIT_ADDR, 1);
    random_points(12, 1'b0);

    set_limit(LIMIT_ADDR, 2);
    quiet = 1'b1;
    random_points(10, 1'b0);
    wait_idle();
    quiet = 1'b0;

    set_limit(LIMIT_ADDR, 16);
    random_points(15, 1'b0);

    // receiver holds off while requests keep coming, so the block backs up
    set_limit(LIMIT_ADDR, $urandom_range(20, 80));
    hold_off = 300;
    random_points(15, 1'b0);

    set_limit(LIMIT_ADDR, 255);
    random_points(15, 1'b0);

    set_limit(LIMIT_ADDR, $urandom_range(4, 300));
    random_points(20, 1'b0);

    set_limit(LIMIT_ADDR, ITER_TOP);
    send_point(point(C_MAX, '0));
    send_point(point('0, C_MIN));
    send_point(point(-2 * ONE_Q, '0));
    random_points(6, 1'b1);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d points sent under %0d iteration limits, %0d results checked",
             board.points, limits_seen, board.results);
    $display("deepest iteration count seen: %0d", board.deepest);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", board.errors,
               board.expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
